// ===== rtl/core/etpi_pkg.sv =====
// ----------------------------------------------------------------------------
// etpi_pkg
// Shared constants, widths and helpers for the escape-time pixel iterator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package etpi_pkg;

  localparam int unsigned FRAC_BITS  = 28;
  localparam int unsigned MAX_ITER   = 1024;
  localparam int unsigned HIST_DEPTH = MAX_ITER + 1;
  localparam int unsigned ITER_W     = 11;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned STEP_W     = 31;
  localparam int unsigned SAT_W      = 48;

  localparam int unsigned S_TDATA_W  = 40;
  localparam int unsigned M_TDATA_W  = 48;
  localparam int unsigned CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IM   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_IM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = 3'd4;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  // reset values of the configuration registers
  localparam logic signed [WORD_W-1:0] RST_MIN_RE   = -32'sd536870912;
  localparam logic signed [WORD_W-1:0] RST_MAX_IM   = 32'sd268435456;
  localparam logic [STEP_W-1:0]        RST_STEP_RE  = 31'd196608;
  localparam logic [STEP_W-1:0]        RST_STEP_IM  = 31'd131072;
  localparam logic [ITER_W-1:0]        RST_MAX_ITER = 11'd256;

  localparam logic [ITER_W-1:0] ITER_CAP = ITER_W'(MAX_ITER);

  // escape radius squared, 4.0 in the squared-magnitude sum width
  localparam logic [35:0] FOUR = 36'(64'd4 << FRAC_BITS);

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(64'sh7FFF_FFFF);
    lo = -SAT_W'(64'sh8000_0000);
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[WORD_W-1:0];
    end
  endfunction

endpackage

// ===== rtl/core/escape_time_pixel_iterator.sv =====
// ----------------------------------------------------------------------------
// escape_time_pixel_iterator
// Mandelbrot escape-time iteration in Q4.28 with an escape-count histogram.
// ----------------------------------------------------------------------------
// Input beats (s_axis): tuser holds the kind. A pixel beat maps column/row to
// c, iterates z = z*z + c from zero until |z|^2 >= 4 or max_iter steps, bumps
// the histogram bin of the count and returns count, in-set flag and new bin
// count. A read beat returns one bin (zero above 1024).
// Output beats (m_axis): exactly one per input beat, in order.
// Config: cfg_we_i / cfg_idx_i / cfg_data_i write one register per edge; the
// user must write only while the block is idle, the block does not enforce it.
// Flow: a pixel runs the c setup states (CMUL_RE, CMUL_IM, CADD), then loops
// CROSS, UPDATE, SQ_RE, SQ_IM per step and ends in HIST_RD and HIST_WR; a
// limit of zero skips the loop, and a read uses BIN_RD and BIN_OUT. Everything
// runs through one 32x32 signed multiplier, used three times per iteration (c
// setup uses it twice). One item is in flight at a time; s_axis_tready is high
// only in idle.
// Reset: registers take their defaults and a clearing pass zeroes the 1025
// histogram bins, one per cycle, with s_axis_tready low.
// A stalled receiver holds the output beat; the next item may be accepted
// meanwhile and then waits for the slot before writing its result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module escape_time_pixel_iterator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // config write port
  input  logic                                cfg_we_i,
  input  logic [etpi_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [etpi_pkg::WORD_W-1:0]         cfg_data_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [etpi_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // column, row, bin, zero pad
  input  logic [0:0]                          s_axis_tuser,  // kind
  // output stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [etpi_pkg::M_TDATA_W-1:0]      m_axis_tdata   // iterations, in_set, bin_count, pad
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CMUL_RE,
    ST_CMUL_IM,
    ST_CADD,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_CROSS,
    ST_UPDATE,
    ST_HIST_RD,
    ST_HIST_WR,
    ST_BIN_RD,
    ST_BIN_OUT
  } state_e;

  localparam int unsigned AW = etpi_pkg::ITER_W;

  state_e state_q;

  // configuration
  logic signed [31:0]  min_re_q, max_im_q;
  logic [30:0]         step_re_q, step_im_q;
  logic [AW-1:0]       max_iter_q;

  // item and datapath
  logic [11:0]         col_q, row_q;
  logic [43:0]         prod_q;
  logic signed [31:0]  cre_q, cim_q, zre_q, zim_q;
  logic [34:0]         pre_q, pim_q;
  logic signed [36:0]  cross_q;
  logic [AW-1:0]       cnt_q, limit;
  logic                first_q;
  logic [AW-1:0]       res_iter_q;
  logic                res_inset_q;
  logic [AW-1:0]       addr_q;
  logic                bin_ok_q;
  logic [AW-1:0]       clr_q;

  // output slot
  logic                m_valid_q;
  logic [AW-1:0]       m_iter_q;
  logic                m_inset_q;
  logic [31:0]         m_count_q;

  // histogram memory
  logic [31:0]         hist_mem [etpi_pkg::HIST_DEPTH];
  logic [31:0]         hist_rdata_q;
  logic                hist_we;
  logic [AW-1:0]       hist_waddr;
  logic [31:0]         hist_wdata;
  logic [31:0]         hist_inc;

  // shared multiplier
  logic signed [31:0]  mul_a, mul_b;
  logic signed [63:0]  mul_p;

  logic                s_acc, out_free, out_load;
  logic [35:0]         mag_sum;
  logic signed [47:0]  re_sum, im_sum, cre_sum, cim_sum;
  logic [AW-1:0]       cnt_inc;
  logic [AW-1:0]       in_bin;

  assign limit    = (max_iter_q > etpi_pkg::ITER_CAP) ? etpi_pkg::ITER_CAP : max_iter_q;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_valid_q || m_axis_tready;
  assign out_load = out_free && ((state_q == ST_HIST_WR) || (state_q == ST_BIN_OUT));
  assign in_bin   = s_axis_tdata[34:24];
  assign cnt_inc  = cnt_q + AW'(1);

  always_comb begin
    case (state_q)
      ST_CMUL_RE: begin
        mul_a = $signed({20'd0, col_q});
        mul_b = $signed({1'b0, step_re_q});
      end
      ST_CMUL_IM: begin
        mul_a = $signed({20'd0, row_q});
        mul_b = $signed({1'b0, step_im_q});
      end
      ST_SQ_RE: begin
        mul_a = zre_q;
        mul_b = zre_q;
      end
      ST_SQ_IM: begin
        mul_a = zim_q;
        mul_b = zim_q;
      end
      default: begin
        mul_a = zre_q;
        mul_b = zim_q;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // squares are nonnegative, so the floored shift is a plain part-select
  assign mag_sum = {1'b0, pre_q} + {1'b0, pim_q};
  assign re_sum  = $signed({13'd0, pre_q}) - $signed({13'd0, pim_q})
                 + 48'(cre_q);
  assign im_sum  = 48'(cross_q) + 48'(cim_q);
  assign cre_sum = 48'(min_re_q) + $signed({4'd0, prod_q});
  assign cim_sum = 48'(max_im_q) - $signed({4'd0, prod_q});

  assign hist_inc = (hist_rdata_q == 32'hFFFF_FFFF) ? hist_rdata_q : hist_rdata_q + 32'd1;

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = addr_q;
    hist_wdata = hist_inc;
    if (state_q == ST_CLEAR) begin
      hist_we    = 1'b1;
      hist_waddr = clr_q;
      hist_wdata = '0;
    end else if (state_q == ST_HIST_WR && out_free) begin
      hist_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    hist_rdata_q <= hist_mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      min_re_q    <= etpi_pkg::RST_MIN_RE;
      max_im_q    <= etpi_pkg::RST_MAX_IM;
      step_re_q   <= etpi_pkg::RST_STEP_RE;
      step_im_q   <= etpi_pkg::RST_STEP_IM;
      max_iter_q  <= etpi_pkg::RST_MAX_ITER;
      col_q       <= '0;
      row_q       <= '0;
      prod_q      <= '0;
      cre_q       <= '0;
      cim_q       <= '0;
      zre_q       <= '0;
      zim_q       <= '0;
      pre_q       <= '0;
      pim_q       <= '0;
      cross_q     <= '0;
      cnt_q       <= '0;
      first_q     <= 1'b0;
      res_iter_q  <= '0;
      res_inset_q <= 1'b0;
      addr_q      <= '0;
      bin_ok_q    <= 1'b0;
      clr_q       <= '0;
      m_valid_q   <= 1'b0;
      m_iter_q    <= '0;
      m_inset_q   <= 1'b0;
      m_count_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          etpi_pkg::CFG_MIN_RE:   min_re_q   <= cfg_data_i;
          etpi_pkg::CFG_MAX_IM:   max_im_q   <= cfg_data_i;
          etpi_pkg::CFG_STEP_RE:  step_re_q  <= cfg_data_i[30:0];
          etpi_pkg::CFG_STEP_IM:  step_im_q  <= cfg_data_i[30:0];
          etpi_pkg::CFG_MAX_ITER: max_iter_q <= cfg_data_i[AW-1:0];
          default: ;
        endcase
      end

      // a beat loaded this cycle replaces the one leaving
      if (m_valid_q && m_axis_tready && !out_load) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == etpi_pkg::ITER_CAP) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_acc) begin
            col_q <= s_axis_tdata[11:0];
            row_q <= s_axis_tdata[23:12];
            if (s_axis_tuser[0] == etpi_pkg::KIND_READ) begin
              bin_ok_q <= (in_bin <= etpi_pkg::ITER_CAP);
              addr_q   <= (in_bin <= etpi_pkg::ITER_CAP) ? in_bin : '0;
              state_q  <= ST_BIN_RD;
            end else begin
              state_q <= ST_CMUL_RE;
            end
          end
        end
        ST_CMUL_RE: begin
          prod_q  <= mul_p[43:0];
          state_q <= ST_CMUL_IM;
        end
        ST_CMUL_IM: begin
          cre_q   <= etpi_pkg::sat32(cre_sum);
          prod_q  <= mul_p[43:0];
          state_q <= ST_CADD;
        end
        ST_CADD: begin
          cim_q   <= etpi_pkg::sat32(cim_sum);
          zre_q   <= '0;
          zim_q   <= '0;
          pre_q   <= '0;
          pim_q   <= '0;
          cnt_q   <= '0;
          first_q <= 1'b1;
          if (limit == '0) begin
            // no step at all: counts as in the set at zero
            res_iter_q  <= '0;
            res_inset_q <= 1'b1;
            addr_q      <= '0;
            state_q     <= ST_HIST_RD;
          end else begin
            state_q <= ST_CROSS;
          end
        end
        ST_SQ_RE: begin
          pre_q   <= mul_p[62:28];
          state_q <= ST_SQ_IM;
        end
        ST_SQ_IM: begin
          pim_q   <= mul_p[62:28];
          state_q <= ST_CROSS;
        end
        ST_CROSS: begin
          // escape test on the z left by the previous update
          cross_q <= mul_p[63:27];
          if (first_q) begin
            first_q <= 1'b0;
            state_q <= ST_UPDATE;
          end else if (mag_sum >= etpi_pkg::FOUR) begin
            res_iter_q  <= cnt_q;
            res_inset_q <= 1'b0;
            addr_q      <= cnt_q;
            state_q     <= ST_HIST_RD;
          end else if (cnt_inc == limit) begin
            res_iter_q  <= cnt_inc;
            res_inset_q <= 1'b1;
            addr_q      <= cnt_inc;
            state_q     <= ST_HIST_RD;
          end else begin
            cnt_q   <= cnt_inc;
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          zre_q   <= etpi_pkg::sat32(re_sum);
          zim_q   <= etpi_pkg::sat32(im_sum);
          state_q <= ST_SQ_RE;
        end
        ST_HIST_RD: begin
          state_q <= ST_HIST_WR;
        end
        ST_HIST_WR: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_iter_q  <= res_iter_q;
            m_inset_q <= res_inset_q;
            m_count_q <= hist_inc;
            state_q   <= ST_IDLE;
          end
        end
        ST_BIN_RD: begin
          state_q <= ST_BIN_OUT;
        end
        ST_BIN_OUT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_iter_q  <= '0;
            m_inset_q <= 1'b0;
            m_count_q <= bin_ok_q ? hist_rdata_q : '0;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'd0, m_count_q, m_inset_q, m_iter_q};

endmodule

// ===== tb/sv/tb_escape_time_pixel_iterator.sv =====
// ----------------------------------------------------------------------------
// tb_escape_time_pixel_iterator
// Self-checking bench for the escape-time pixel iterator.
// Drives pixel and histogram-read beats over the input stream. A local
// fixed-point model predicts each result beat (escape count, in-set flag and
// bin count), including its own copy of the histogram. The bench covers
// directed corners first (first-step escape, zero and clamped limits,
// saturated coordinates, reads past the histogram) and then random zoom
// windows around the set boundary plus random register noise. Output
// back-pressure is randomized throughout, input gaps in the random phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_escape_time_pixel_iterator;

  localparam int unsigned CYCLE_LIMIT = 20_000_000;

  typedef struct packed {
    logic        kind;
    logic [11:0] column;
    logic [11:0] row;
    logic [10:0] bin;
  } pix_item_t;

  typedef struct packed {
    logic [10:0] iterations;
    logic        in_set;
    logic [31:0] bin_count;
  } pix_result_t;

  logic                           clk_i;
  logic                           rst_n     = 1'b0;
  logic                           cfg_we    = 1'b0;
  logic [etpi_pkg::CFG_IDX_W-1:0] cfg_idx   = '0;
  logic [etpi_pkg::WORD_W-1:0]    cfg_data  = '0;
  logic                           src_valid = 1'b0;
  logic [etpi_pkg::S_TDATA_W-1:0] src_data  = '0;
  logic [0:0]                     src_kind  = '0;
  logic                           rx_ready  = 1'b0;
  logic                           s_axis_tready;
  logic                           m_axis_tvalid;
  logic [etpi_pkg::M_TDATA_W-1:0] m_axis_tdata;

  escape_time_pixel_iterator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (src_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (src_data),   // column, row, bin, zero pad
    .s_axis_tuser  (src_kind),   // kind
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (rx_ready),
    .m_axis_tdata  (m_axis_tdata) // iterations, in_set, bin_count, pad
  );

  // model state
  longint      reg_min_re;
  longint      reg_max_im;
  longint      reg_step_re;
  longint      reg_step_im;
  int unsigned reg_max_iter;
  logic [31:0] hist_model [0:etpi_pkg::HIST_DEPTH-1];

  pix_result_t pending_results [$];
  int unsigned err_count   = 0;
  int unsigned beat_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left  = 0;
  bit          steady      = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic longint clamp_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor(a^2 / 2^FRAC_BITS); magnitude squared is non-negative so a plain shift floors
  function automatic longint square_frac(longint a);
    longint unsigned m;
    m = (a < 0) ? -a : a;
    return longint'((m * m) >> etpi_pkg::FRAC_BITS);
  endfunction

  function automatic pix_result_t escape_count_predict(pix_item_t it);
    pix_result_t r;
    longint      c_re, c_im, z_re, z_im, n_re, n_im, four_q;
    int unsigned lim, k;
    logic        bounded;
    r = '0;
    if (it.kind == etpi_pkg::KIND_READ) begin
      r.bin_count = (it.bin <= etpi_pkg::MAX_ITER) ? hist_model[it.bin] : 32'd0;
      return r;
    end
    c_re    = clamp_word(reg_min_re + longint'(it.column) * reg_step_re);
    c_im    = clamp_word(reg_max_im - longint'(it.row) * reg_step_im);
    lim     = (reg_max_iter > etpi_pkg::MAX_ITER) ? etpi_pkg::MAX_ITER : reg_max_iter;
    four_q  = longint'(4) << etpi_pkg::FRAC_BITS;
    z_re    = 0;
    z_im    = 0;
    bounded = 1'b1;
    k       = 0;
    while (k < lim) begin
      n_re = clamp_word(square_frac(z_re) - square_frac(z_im) + c_re);
      n_im = clamp_word(((z_re * z_im) >>> (etpi_pkg::FRAC_BITS - 1)) + c_im);
      z_re = n_re;
      z_im = n_im;
      if (square_frac(z_re) + square_frac(z_im) >= four_q) begin
        bounded = 1'b0;
        break;
      end
      k++;
    end
    if (hist_model[k] != 32'hFFFF_FFFF) hist_model[k] = hist_model[k] + 1;
    r.iterations = etpi_pkg::ITER_W'(k);
    r.in_set     = bounded;
    r.bin_count  = hist_model[k];
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("[%0t] beat %0d %s: got %0d, expected %0d", $time, beat_count, what, got, want);
    err_count++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    pix_result_t got, want;
    if (rst_n && m_axis_tvalid && rx_ready) begin
      got.iterations = m_axis_tdata[10:0];
      got.in_set     = m_axis_tdata[11];
      got.bin_count  = m_axis_tdata[43:12];
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected beat, bin_count", got.bin_count, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.iterations != want.iterations)
          flag_mismatch("iterations", got.iterations, want.iterations);
        if (got.in_set != want.in_set)
          flag_mismatch("in_set", got.in_set, want.in_set);
        if (got.bin_count != want.bin_count)
          flag_mismatch("bin_count", got.bin_count, want.bin_count);
      end
      beat_count++;
    end
  end

  // output back-pressure: a new mode is drawn whenever rx_tick wraps
  logic [7:0] rx_tick   = '0;
  int         rx_mode   = 0;
  int         hold_left = 0;
  always @(negedge clk_i) begin
    rx_tick <= rx_tick + 8'd1;
    if (rx_tick == 8'd0) rx_mode <= $urandom_range(0, 2);
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rx_ready  <= 1'b0;
    end else if (rx_mode == 2 && $urandom_range(0, 7) == 0) begin
      hold_left <= $urandom_range(1, 40);
      rx_ready  <= 1'b0;
    end else begin
      rx_ready <= (rx_mode != 1) || ($urandom_range(0, 3) != 0);
    end
  end

  task automatic send_item(logic kind, logic [11:0] col, logic [11:0] row, logic [10:0] bin);
    pix_item_t it;
    it = '{kind: kind, column: col, row: row, bin: bin};
    @(negedge clk_i);
    src_valid <= 1'b1;
    src_kind  <= kind;
    src_data  <= {5'b0, bin, row, col};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(escape_count_predict(it));
  endtask

  task automatic pixel(logic [11:0] col, logic [11:0] row);
    send_item(etpi_pkg::KIND_PIXEL, col, row, 11'($urandom));
  endtask

  task automatic read_bin(logic [10:0] bin);
    send_item(etpi_pkg::KIND_READ, 12'($urandom), 12'($urandom), bin);
  endtask

  // bursts of beats with random gaps between them
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      if (gap != 0) begin
        @(negedge clk_i) src_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // wait for the block to go idle with nothing outstanding
  task automatic settle();
    @(negedge clk_i) src_valid <= 1'b0;
    while (pending_results.size() != 0 || !s_axis_tready) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [etpi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    case (idx)
      etpi_pkg::CFG_MIN_RE:   reg_min_re   = longint'($signed(value));
      etpi_pkg::CFG_MAX_IM:   reg_max_im   = longint'($signed(value));
      etpi_pkg::CFG_STEP_RE:  reg_step_re  = longint'(value[30:0]);
      etpi_pkg::CFG_STEP_IM:  reg_step_im  = longint'(value[30:0]);
      etpi_pkg::CFG_MAX_ITER: reg_max_iter = value[10:0];
      default: ;
    endcase
  endtask

  task automatic random_item(int unsigned pct_read);
    logic [10:0] bin;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 7)      bin = 11'($urandom_range(0, 64));
    else if (pick < 9) bin = 11'($urandom_range(0, etpi_pkg::MAX_ITER));
    else               bin = 11'($urandom_range(etpi_pkg::MAX_ITER + 1, 2047));
    pace_sender();
    send_item(($urandom_range(0, 99) < pct_read) ? etpi_pkg::KIND_READ : etpi_pkg::KIND_PIXEL,
              12'($urandom), 12'($urandom), bin);
  endtask

  // default view, first-step escapes and the |c| = 2 boundary
  task automatic test_reset_view();
    read_bin(11'd0);
    read_bin(11'd1024);
    read_bin(11'd1025);
    read_bin(11'd2047);
    pixel(12'd0, 12'd0);        // -2 + 1i
    pixel(12'd0, 12'd2048);     // exactly -2: sum hits 4 on the first step
    pixel(12'd2730, 12'd2048);  // near the origin, stays bounded
    pixel(12'd4095, 12'd4095);
    pixel(12'd4095, 12'd0);
    read_bin(11'd0);
    read_bin(11'd256);
    settle();
  endtask

  task automatic test_iteration_limits();
    write_reg(etpi_pkg::CFG_MAX_ITER, 32'd0);
    pixel(12'd2730, 12'd2048);
    pixel(12'd0, 12'd0);        // no step runs, so even this counts as in the set
    read_bin(11'd0);
    settle();
    write_reg(etpi_pkg::CFG_MAX_ITER, 32'd1);
    pixel(12'd2730, 12'd2048);
    settle();
    write_reg(etpi_pkg::CFG_MAX_ITER, 32'd1024);
    pixel(12'd2730, 12'd2048);
    settle();
    // above the cap, treated as 1024
    write_reg(etpi_pkg::CFG_MAX_ITER, 32'hFFFF_FFFF);
    pixel(12'd2730, 12'd2048);
    read_bin(11'd1024);
    settle();
  endtask

  task automatic test_saturation();
    write_reg(etpi_pkg::CFG_MIN_RE, 32'h8000_0000);
    write_reg(etpi_pkg::CFG_MAX_IM, 32'h7FFF_FFFF);
    write_reg(etpi_pkg::CFG_STEP_RE, 32'h7FFF_FFFF);
    write_reg(etpi_pkg::CFG_STEP_IM, 32'hFFFF_FFFF);
    write_reg(etpi_pkg::CFG_MAX_ITER, 32'd8);
    pixel(12'd0, 12'd0);
    pixel(12'd4095, 12'd4095);  // both coordinates clamp
    pixel(12'd1, 12'd1);
    settle();
    write_reg(etpi_pkg::CFG_MIN_RE, 32'h7FFF_FFFF);
    write_reg(etpi_pkg::CFG_MAX_IM, 32'h8000_0000);
    write_reg(etpi_pkg::CFG_STEP_RE, 32'd0);
    write_reg(etpi_pkg::CFG_STEP_IM, 32'd0);
    pixel(12'hFFF, 12'h000);
    pixel(12'h000, 12'hFFF);
    settle();
  endtask

  // zoom windows around points on or near the set boundary
  task automatic test_random_windows(int phases, int items);
    real         c_re, c_im;
    int unsigned s_re, s_im, lim;
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 8))
        0: begin c_re = -0.7436; c_im = 0.1318; end
        1: begin c_re = -0.75;   c_im = 0.0;    end
        2: begin c_re = -1.25;   c_im = 0.0;    end
        3: begin c_re = 0.25;    c_im = 0.0;    end
        4: begin c_re = -0.1;    c_im = 0.65;   end
        5: begin c_re = 0.3;     c_im = 0.5;    end
        6: begin c_re = -1.77;   c_im = 0.0;    end
        7: begin c_re = -0.5;    c_im = 0.55;   end
        default: begin c_re = -0.5; c_im = 0.0; end
      endcase
      s_re = $urandom_range(64, 196608);
      s_im = ($urandom_range(0, 1) == 1) ? s_re : $urandom_range(64, 196608);
      if (p == phases - 1)
        lim = ($urandom_range(0, 1) == 1) ? 1024 : $urandom_range(1025, 2047);
      else if ($urandom_range(0, 3) == 0)
        lim = $urandom_range(128, 300);
      else
        lim = $urandom_range(1, 64);
      write_reg(etpi_pkg::CFG_MIN_RE,
                32'($rtoi(c_re * 268435456.0) - longint'(s_re) * 2048));
      write_reg(etpi_pkg::CFG_MAX_IM,
                32'($rtoi(c_im * 268435456.0) + longint'(s_im) * 2048));
      write_reg(etpi_pkg::CFG_STEP_RE, s_re);
      write_reg(etpi_pkg::CFG_STEP_IM, s_im);
      write_reg(etpi_pkg::CFG_MAX_ITER, lim);
      steady     = ($urandom_range(0, 3) == 0);
      burst_left = 0;
      repeat (items) random_item(15);
      settle();
    end
  endtask

  // raw register values, junk in unused bits, mostly fast escapes
  task automatic test_random_registers(int phases, int items);
    for (int p = 0; p < phases; p++) begin
      write_reg(etpi_pkg::CFG_MIN_RE, $urandom);
      write_reg(etpi_pkg::CFG_MAX_IM, $urandom);
      write_reg(etpi_pkg::CFG_STEP_RE, $urandom);
      write_reg(etpi_pkg::CFG_STEP_IM, $urandom);
      write_reg(etpi_pkg::CFG_MAX_ITER, $urandom);
      steady     = 1'b0;
      burst_left = 0;
      repeat (items) random_item(25);
      settle();
    end
  endtask

  initial begin
    reg_min_re   = longint'(etpi_pkg::RST_MIN_RE);
    reg_max_im   = longint'(etpi_pkg::RST_MAX_IM);
    reg_step_re  = longint'(etpi_pkg::RST_STEP_RE);
    reg_step_im  = longint'(etpi_pkg::RST_STEP_IM);
    reg_max_iter = etpi_pkg::RST_MAX_ITER;
    foreach (hist_model[i]) hist_model[i] = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_n <= 1'b1;
    settle();

    test_reset_view();
    test_iteration_limits();
    test_saturation();
    test_random_windows(7, 70);
    test_random_registers(3, 30);

    settle();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
